// File: sv/lsrc_pkg.sv
// ----------------------------------------------------------------------------
// lsrc_pkg: shared constants for the line segment rectangle clipper
// Default widths, configuration address width and register addresses.
// ----------------------------------------------------------------------------
package lsrc_pkg;

	localparam int COORD_BITS_DEF = 16;
	localparam int FRAC_BITS_DEF  = 16;
	localparam int CFG_ADDR_BITS  = 4;

	localparam logic [CFG_ADDR_BITS-1:0] REG_X_MIN = CFG_ADDR_BITS'(0);
	localparam logic [CFG_ADDR_BITS-1:0] REG_X_MAX = CFG_ADDR_BITS'(1);
	localparam logic [CFG_ADDR_BITS-1:0] REG_Y_MIN = CFG_ADDR_BITS'(2);
	localparam logic [CFG_ADDR_BITS-1:0] REG_Y_MAX = CFG_ADDR_BITS'(3);

endpackage

// File: sv/lsrc_cfg_if.sv
// ----------------------------------------------------------------------------
// lsrc_cfg_if: configuration write channel
// Valid/ready channel carrying a register address and write data.
// ----------------------------------------------------------------------------
interface lsrc_cfg_if #(
	parameter int ADDR_BITS = 4,
	parameter int DATA_BITS = 16
);
	logic                 valid;
	logic                 ready;
	logic [ADDR_BITS-1:0] addr;
	logic [DATA_BITS-1:0] data;

	modport source (output valid, output addr, output data, input ready);
	modport sink   (input valid, input addr, input data, output ready);
endinterface

// File: sv/lsrc_seg_if.sv
// ----------------------------------------------------------------------------
// lsrc_seg_if: segment input channel
// Valid/ready channel carrying the two endpoints of one segment.
// ----------------------------------------------------------------------------
interface lsrc_seg_if #(
	parameter int COORD_BITS = 16
);
	logic                         valid;
	logic                         ready;
	logic signed [COORD_BITS-1:0] start_x;
	logic signed [COORD_BITS-1:0] start_y;
	logic signed [COORD_BITS-1:0] end_x;
	logic signed [COORD_BITS-1:0] end_y;

	modport source (output valid, output start_x, output start_y, output end_x,
		output end_y, input ready);
	modport sink   (input valid, input start_x, input start_y, input end_x,
		input end_y, output ready);
endinterface

// File: sv/lsrc_res_if.sv
// ----------------------------------------------------------------------------
// lsrc_res_if: clip result channel
// Valid/ready channel carrying the clipped segment and its parameters.
// ----------------------------------------------------------------------------
interface lsrc_res_if #(
	parameter int COORD_BITS = 16,
	parameter int U_BITS     = 19
);
	logic                         valid;
	logic                         ready;
	logic                         visible;
	logic signed [COORD_BITS-1:0] clip_x0;
	logic signed [COORD_BITS-1:0] clip_y0;
	logic signed [COORD_BITS-1:0] clip_x1;
	logic signed [COORD_BITS-1:0] clip_y1;
	logic signed [U_BITS-1:0]     u_enter;
	logic signed [U_BITS-1:0]     u_exit;

	modport source (output valid, output visible, output clip_x0, output clip_y0,
		output clip_x1, output clip_y1, output u_enter, output u_exit, input ready);
	modport sink   (input valid, input visible, input clip_x0, input clip_y0,
		input clip_x1, input clip_y1, input u_enter, input u_exit, output ready);
endinterface

// File: sv/line_segment_rect_clipper.sv
// ----------------------------------------------------------------------------
// line_segment_rect_clipper: Liang-Barsky segment clipper
// Clips one integer segment per cycle against a configurable window.
// ----------------------------------------------------------------------------
// Usage: write the window edges on cfg (x_min, x_max, y_min, y_max at
// addresses 0..3) while the block is idle; cfg is always ready. Each word on
// seg is one segment; each word on res is its clip result. The window is
// held in flip-flops and read when a segment enters the first stage.
// A segment passes from seg to res through one edge stage, FRAC_BITS + 1
// restoring division stages producing one quotient bit each, a select
// stage, a multiply stage, a sum and magnitude stage and a round and output
// stage. Throughput is one segment per cycle while res is ready. Every
// stage has its own valid bit and advances when it is empty or the stage
// after it advances, so bubbles collapse and seg stays ready while a
// finished word waits on res until the pipeline is full. When res stalls
// with a full pipeline seg.ready drops and nothing is lost or repeated.
// Reset clears all valid bits and loads the window registers with x_min =
// y_min = 0 and x_max = y_max = the largest positive coordinate.
// ----------------------------------------------------------------------------
module line_segment_rect_clipper #(
	parameter int COORD_BITS = lsrc_pkg::COORD_BITS_DEF,
	parameter int FRAC_BITS  = lsrc_pkg::FRAC_BITS_DEF
) (
	input logic     clk,
	input logic     arst_n,
	lsrc_cfg_if.sink    cfg,
	lsrc_seg_if.sink    seg,
	lsrc_res_if.source  res
);
	import lsrc_pkg::*;

	localparam int C   = COORD_BITS;
	localparam int F   = FRAC_BITS;
	localparam int MB  = C + 1;
	localparam int QB  = F + 1;
	localparam int UW  = F + 3;
	localparam int PW  = C + 1 + UW;
	localparam int SW  = PW + 1;
	localparam int ST_SR = F + 2;
	localparam int ST_SM = F + 3;
	localparam int ST_SA = F + 4;
	localparam int ST_SO = F + 5;
	localparam int NS    = F + 6;

	localparam logic signed [UW-1:0] U_ONE   = UW'(1) << F;
	localparam logic [F+1:0]         U_SATM  = (F+2)'(1) << (F + 1);
	localparam logic [SW-1:0]        HALF    = SW'(1) << (F - 1);
	localparam logic [SW-1:0]        POS_MAX = (SW'(1) << (C - 1)) - SW'(1);
	localparam logic [SW-1:0]        NEG_MAX = SW'(1) << (C - 1);

	typedef struct packed {
		logic signed [C-1:0] x0;
		logic signed [C-1:0] y0;
		logic signed [C:0]   dx;
		logic signed [C:0]   dy;
		logic                par;
		logic [3:0]          negp;
		logic [3:0]          posp;
		logic [3:0]          negq;
	} side_t;

	// window registers
	logic signed [C-1:0] win_x_min_q, win_x_max_q, win_y_min_q, win_y_max_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_x_min_q <= '0;
			win_x_max_q <= C'((1 << (C - 1)) - 1);
			win_y_min_q <= '0;
			win_y_max_q <= C'((1 << (C - 1)) - 1);
		end else if (cfg.valid) begin
			case (cfg.addr)
				REG_X_MIN: win_x_min_q <= cfg.data;
				REG_X_MAX: win_x_max_q <= cfg.data;
				REG_Y_MIN: win_y_min_q <= cfg.data;
				REG_Y_MAX: win_y_max_q <= cfg.data;
				default: ;
			endcase
		end
	end

	// pipeline control
	logic [NS-1:0] vld_q;
	logic [NS:0]   en;

	always_comb begin
		en[NS] = res.ready;
		for (int k = NS - 1; k >= 0; k--) begin
			en[k] = !vld_q[k] || en[k+1];
		end
	end

	assign seg.ready = en[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[0]) begin
				vld_q[0] <= seg.valid;
			end
			for (int k = 1; k < NS; k++) begin
				if (en[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	// stage 1: edge terms
	logic signed [C:0] x0e, y0e, dxc, dyc;
	logic signed [C:0] qc [4];
	logic [MB-1:0]     qmag [4];
	logic [MB-1:0]     dxm, dym;
	side_t             side_c;

	function automatic logic [MB-1:0] mag_of(input logic signed [C:0] v);
		logic signed [C:0] n;
		begin
			n = -v;
			mag_of = v[C] ? n : v;
		end
	endfunction

	always_comb begin
		x0e   = (C+1)'(seg.start_x);
		y0e   = (C+1)'(seg.start_y);
		dxc   = (C+1)'(seg.end_x) - x0e;
		dyc   = (C+1)'(seg.end_y) - y0e;
		qc[0] = x0e - (C+1)'(win_x_min_q);
		qc[1] = (C+1)'(win_x_max_q) - x0e;
		qc[2] = y0e - (C+1)'(win_y_min_q);
		qc[3] = (C+1)'(win_y_max_q) - y0e;
		for (int i = 0; i < 4; i++) begin
			qmag[i] = mag_of(qc[i]);
		end
		dxm = mag_of(dxc);
		dym = mag_of(dyc);
		side_c.x0   = seg.start_x;
		side_c.y0   = seg.start_y;
		side_c.dx   = dxc;
		side_c.dy   = dyc;
		side_c.par  = ((dxc == '0) && (qc[0][C] || qc[1][C]))
			|| ((dyc == '0) && (qc[2][C] || qc[3][C]));
		side_c.negp = {dyc < 0, dyc > 0, dxc < 0, dxc > 0};
		side_c.posp = {dyc > 0, dyc < 0, dxc > 0, dxc < 0};
		side_c.negq = {qc[3][C], qc[2][C], qc[1][C], qc[0][C]};
	end

	side_t         side_s [0:F+1];
	logic [MB-1:0] pmag_s1 [4];
	logic [MB-1:0] qmag_s1 [4];

	always_ff @(posedge clk) begin
		if (en[0]) begin
			side_s[0] <= side_c;
			pmag_s1[0] <= dxm;
			pmag_s1[1] <= dxm;
			pmag_s1[2] <= dym;
			pmag_s1[3] <= dym;
			for (int i = 0; i < 4; i++) begin
				qmag_s1[i] <= qmag[i];
			end
		end
	end

	// division stages: |q| * 2^F / |p|, one quotient bit per stage
	logic [MB-1:0] den_sd [4][0:F];
	logic [MB:0]   rem_sd [4][0:F];
	logic [QB-1:0] quo_sd [4][0:F];
	logic          sat_sd [4][0:F];

	for (genvar i = 0; i < 4; i++) begin : g_lane
		for (genvar j = 0; j <= F; j++) begin : g_step
			if (j == 0) begin : g_first
				lsrc_div_stage #(
					.MAG_BITS (MB),
					.QUO_BITS (QB),
					.BIT_POS  (F),
					.FIRST    (1'b1)
				) u_div (
					.clk   (clk),
					.en    (en[1]),
					.den_i (pmag_s1[i]),
					.rem_i ({1'b0, qmag_s1[i]}),
					.quo_i ('0),
					.sat_i (1'b0),
					.den_o (den_sd[i][0]),
					.rem_o (rem_sd[i][0]),
					.quo_o (quo_sd[i][0]),
					.sat_o (sat_sd[i][0])
				);
			end else begin : g_next
				lsrc_div_stage #(
					.MAG_BITS (MB),
					.QUO_BITS (QB),
					.BIT_POS  (F - j),
					.FIRST    (1'b0)
				) u_div (
					.clk   (clk),
					.en    (en[j+1]),
					.den_i (den_sd[i][j-1]),
					.rem_i (rem_sd[i][j-1]),
					.quo_i (quo_sd[i][j-1]),
					.sat_i (sat_sd[i][j-1]),
					.den_o (den_sd[i][j]),
					.rem_o (rem_sd[i][j]),
					.quo_o (quo_sd[i][j]),
					.sat_o (sat_sd[i][j])
				);
			end
		end
	end

	for (genvar j = 0; j <= F; j++) begin : g_side
		always_ff @(posedge clk) begin
			if (en[j+1]) begin
				side_s[j+1] <= side_s[j];
			end
		end
	end

	// select stage: signed ratios, entering max and exiting min
	logic signed [UW-1:0] ratio [4];
	logic signed [UW-1:0] ue_c, ux_c;
	side_t                sf;

	always_comb begin
		logic [F+1:0]         m;
		logic signed [UW-1:0] rs;
		sf   = side_s[F+1];
		ue_c = '0;
		ux_c = U_ONE;
		for (int i = 0; i < 4; i++) begin
			m  = sat_sd[i][F] ? U_SATM : {1'b0, quo_sd[i][F]};
			rs = UW'(m);
			ratio[i] = (sf.negp[i] ^ sf.negq[i]) ? -rs : rs;
			if (sf.negp[i] && (ratio[i] > ue_c)) begin
				ue_c = ratio[i];
			end
			if (sf.posp[i] && (ratio[i] < ux_c)) begin
				ux_c = ratio[i];
			end
		end
	end

	logic signed [UW-1:0] ue_s3, ux_s3;
	logic signed [C-1:0]  x0_s3, y0_s3;
	logic signed [C:0]    dx_s3, dy_s3;
	logic                 par_s3;

	always_ff @(posedge clk) begin
		if (en[ST_SR]) begin
			ue_s3  <= ue_c;
			ux_s3  <= ux_c;
			x0_s3  <= sf.x0;
			y0_s3  <= sf.y0;
			dx_s3  <= sf.dx;
			dy_s3  <= sf.dy;
			par_s3 <= sf.par;
		end
	end

	// multiply stage
	logic signed [PW-1:0] prod_s4 [4];
	logic signed [C-1:0]  base_s4 [4];
	logic signed [UW-1:0] ue_s4, ux_s4;
	logic                 par_s4, rej_s4;

	always_ff @(posedge clk) begin
		if (en[ST_SM]) begin
			prod_s4[0] <= PW'(dx_s3) * PW'(ue_s3);
			prod_s4[1] <= PW'(dy_s3) * PW'(ue_s3);
			prod_s4[2] <= PW'(dx_s3) * PW'(ux_s3);
			prod_s4[3] <= PW'(dy_s3) * PW'(ux_s3);
			base_s4[0] <= x0_s3;
			base_s4[1] <= y0_s3;
			base_s4[2] <= x0_s3;
			base_s4[3] <= y0_s3;
			ue_s4  <= ue_s3;
			ux_s4  <= ux_s3;
			par_s4 <= par_s3;
			rej_s4 <= (ue_s3 > ux_s3);
		end
	end

	// sum and magnitude stage
	logic [SW-1:0]        mag_s5 [4];
	logic [3:0]           neg_s5;
	logic signed [UW-1:0] ue_s5, ux_s5;
	logic                 par_s5, rej_s5;

	always_ff @(posedge clk) begin
		if (en[ST_SA]) begin
			for (int i = 0; i < 4; i++) begin
				logic signed [SW-1:0] s;
				s = (SW'(base_s4[i]) <<< F) + SW'(prod_s4[i]);
				mag_s5[i] <= s[SW-1] ? -s : s;
				neg_s5[i] <= s[SW-1];
			end
			ue_s5  <= ue_s4;
			ux_s5  <= ux_s4;
			par_s5 <= par_s4;
			rej_s5 <= rej_s4;
		end
	end

	// round, saturate and output register
	logic signed [C-1:0] pt_c [4];

	always_comb begin
		logic [SW-1:0] r;
		for (int i = 0; i < 4; i++) begin
			r = (mag_s5[i] + HALF) >> F;
			if (!neg_s5[i] && (r > POS_MAX)) begin
				r = POS_MAX;
			end
			if (neg_s5[i] && (r > NEG_MAX)) begin
				r = NEG_MAX;
			end
			pt_c[i] = neg_s5[i] ? -r[C-1:0] : r[C-1:0];
		end
	end

	logic                 vis_s6;
	logic signed [C-1:0]  pt_s6 [4];
	logic signed [UW-1:0] ue_s6, ux_s6;

	always_ff @(posedge clk) begin
		if (en[ST_SO]) begin
			vis_s6 <= !par_s5 && !rej_s5;
			for (int i = 0; i < 4; i++) begin
				pt_s6[i] <= (!par_s5 && !rej_s5) ? pt_c[i] : '0;
			end
			ue_s6 <= par_s5 ? '0 : ue_s5;
			ux_s6 <= par_s5 ? '0 : ux_s5;
		end
	end

	assign res.valid   = vld_q[NS-1];
	assign res.visible = vis_s6;
	assign res.clip_x0 = pt_s6[0];
	assign res.clip_y0 = pt_s6[1];
	assign res.clip_x1 = pt_s6[2];
	assign res.clip_y1 = pt_s6[3];
	assign res.u_enter = ue_s6;
	assign res.u_exit  = ux_s6;

	a_vis_order: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.visible |-> res.u_enter <= res.u_exit)
		else $error("visible result with entering above exiting");

	a_vis_range: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.visible |-> res.u_enter >= 0 && res.u_exit <= U_ONE)
		else $error("visible result with parameter outside 0..1");

	a_ready_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!vld_q[NS-1] |-> seg.ready)
		else $error("input stalled while output stage empty");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && !res.ready |=> res.valid)
		else $error("result word dropped under stall");
endmodule

// File: sv/lsrc_div_stage.sv
// ----------------------------------------------------------------------------
// lsrc_div_stage: one restoring division step
// Produces one quotient bit per stage; the first stage also flags overflow.
// ----------------------------------------------------------------------------
module lsrc_div_stage #(
	parameter int MAG_BITS = 17,
	parameter int QUO_BITS = 17,
	parameter int BIT_POS  = 16,
	parameter bit FIRST    = 1'b0
) (
	input  logic                clk,
	input  logic                en,
	input  logic [MAG_BITS-1:0] den_i,
	input  logic [MAG_BITS:0]   rem_i,
	input  logic [QUO_BITS-1:0] quo_i,
	input  logic                sat_i,
	output logic [MAG_BITS-1:0] den_o,
	output logic [MAG_BITS:0]   rem_o,
	output logic [QUO_BITS-1:0] quo_o,
	output logic                sat_o
);
	logic [MAG_BITS:0] trial;
	logic [MAG_BITS:0] den_x;
	logic              ge;
	logic [QUO_BITS-1:0] quo_n;

	always_comb begin
		den_x = {1'b0, den_i};
		trial = FIRST ? rem_i : {rem_i[MAG_BITS-1:0], 1'b0};
		ge    = (trial >= den_x);
		quo_n = quo_i;
		quo_n[BIT_POS] = ge;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			den_o <= den_i;
			rem_o <= ge ? (trial - den_x) : trial;
			quo_o <= quo_n;
			sat_o <= FIRST ? (rem_i >= {den_i, 1'b0}) : sat_i;
		end
	end
endmodule
